@@ src/stq_pkg.sv @@
// ----------------------------------------------------------------------------
// stq_pkg: sorted timer queue shared definitions
// Sizes, command and status codes, store request and cell types.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int TIMERS      = 16;
    localparam int TIME_BITS   = 32;
    localparam int TAG_BITS    = 16;
    localparam int HANDLES     = 16;
    localparam int HANDLE_BITS = 4;
    localparam int MAX_RESULTS = 16;

    localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CNT_W = $clog2(TIMERS + 1);
    localparam int POP_W = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_ADJUST = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_IN_USE   = 2'd1;
    localparam logic [1:0] ST_NOT_USED = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_INS  = 2'd1,
        OP_REM  = 2'd2
    } store_op_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]   expire;
        logic [TAG_BITS-1:0]    tag;
        logic [HANDLE_BITS-1:0] handle;
    } cell_t;

    typedef struct packed {
        store_op_t  op;
        logic [IDX_W-1:0] pos;
        cell_t      entry;
    } store_req_t;

    typedef struct packed {
        logic le;   // cell expiry <= operand time
        logic eq;   // cell handle == operand handle
    } cmp_res_t;

endpackage

@@ src/stq_store.sv @@
// ----------------------------------------------------------------------------
// stq_store: ordered timer cell store
// Cells packed from index 0; insert shifts up, remove shifts down.
// ----------------------------------------------------------------------------
module stq_store import stq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  store_req_t       req,
    input  logic [IDX_W-1:0] rd_idx,
    output cell_t            rd_cell,
    output logic [CNT_W-1:0] count
);

    cell_t            cell_reg  [TIMERS];
    cell_t            cell_next [TIMERS];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        for (int i = 0; i < TIMERS; i++)
        begin
            cell_next[i] = cell_reg[i];
        end
        count_next = count_reg;
        case (req.op)
            OP_INS:
            begin
                for (int i = 1; i < TIMERS; i++)
                begin
                    if (IDX_W'(i) > req.pos)
                    begin
                        cell_next[i] = cell_reg[i-1];
                    end
                end
                for (int i = 0; i < TIMERS; i++)
                begin
                    if (IDX_W'(i) == req.pos)
                    begin
                        cell_next[i] = req.entry;
                    end
                end
                count_next = count_reg + CNT_W'(1);
            end
            OP_REM:
            begin
                for (int i = 0; i < TIMERS - 1; i++)
                begin
                    if (IDX_W'(i) >= req.pos)
                    begin
                        cell_next[i] = cell_reg[i+1];
                    end
                end
                count_next = count_reg - CNT_W'(1);
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        rd_cell = '0;
        for (int i = 0; i < TIMERS; i++)
        begin
            if (IDX_W'(i) == rd_idx)
            begin
                rd_cell = cell_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TIMERS; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

@@ src/stq_cmp.sv @@
// ----------------------------------------------------------------------------
// stq_cmp: shared compare unit
// One time compare and one handle match, reused by every scan step.
// ----------------------------------------------------------------------------
module stq_cmp import stq_pkg::*;
(
    input  cell_t                  entry,
    input  logic [TIME_BITS-1:0]   op_time,
    input  logic [HANDLE_BITS-1:0] op_handle,
    output cmp_res_t               res
);

    assign res.le = (entry.expire <= op_time);
    assign res.eq = (entry.handle == op_handle);

endmodule

@@ src/stq_seq.sv @@
// ----------------------------------------------------------------------------
// stq_seq: command sequencer
// Walks the store one cell per cycle through the shared compare unit,
// issues insert and remove requests and registers each result word.
// ----------------------------------------------------------------------------
module stq_seq import stq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1:0]             command,
    input  logic [HANDLE_BITS-1:0] handle,
    input  logic [TIME_BITS-1:0]   expire,
    input  logic [TAG_BITS-1:0]    client_tag,
    input  logic [TIME_BITS-1:0]   now,
    output logic                   busy,
    input  cell_t                  rd_cell,
    input  logic [CNT_W-1:0]       count,
    input  cmp_res_t               cmp,
    output logic [IDX_W-1:0]       rd_idx,
    output logic [TIME_BITS-1:0]   op_time,
    output logic [HANDLE_BITS-1:0] op_handle,
    output store_req_t             req,
    output logic                   done,
    output logic [1:0]             status,
    output logic                   expired_valid,
    output logic [HANDLE_BITS-1:0] expired_handle,
    output logic [TAG_BITS-1:0]    expired_tag,
    output logic                   last
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FIND = 4'b0100,
        S_POP  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [1:0]             cmd_reg, cmd_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic [TIME_BITS-1:0]   time_reg, time_next;
    logic [TAG_BITS-1:0]    tag_reg, tag_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [POP_W-1:0]       pop_cnt_reg, pop_cnt_next;
    logic                   pend_reg, pend_next;
    logic [HANDLE_BITS-1:0] pend_handle_reg, pend_handle_next;
    logic [TAG_BITS-1:0]    pend_tag_reg, pend_tag_next;
    logic [HANDLES-1:0]     in_use_reg, in_use_next;

    logic                   done_reg, done_next;
    logic [1:0]             status_reg, status_next;
    logic                   xv_reg, xv_next;
    logic [HANDLE_BITS-1:0] xh_reg, xh_next;
    logic [TAG_BITS-1:0]    xt_reg, xt_next;
    logic                   last_reg, last_next;

    logic full;
    logic pop;

    assign full = (count == CNT_W'(TIMERS));
    assign pop  = (count != '0) && cmp.le && (pop_cnt_reg != POP_W'(MAX_RESULTS));

    assign rd_idx    = (state_reg == S_POP) ? '0 : idx_reg[IDX_W-1:0];
    assign op_time   = time_reg;
    assign op_handle = handle_reg;
    assign busy      = (state_reg != S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        handle_next      = handle_reg;
        time_next        = time_reg;
        tag_next         = tag_reg;
        idx_next         = idx_reg;
        pop_cnt_next     = pop_cnt_reg;
        pend_next        = pend_reg;
        pend_handle_next = pend_handle_reg;
        pend_tag_next    = pend_tag_reg;
        in_use_next      = in_use_reg;

        done_next   = 1'b0;
        status_next = status_reg;
        xv_next     = xv_reg;
        xh_next     = xh_reg;
        xt_next     = xt_reg;
        last_next   = last_reg;

        req.op           = OP_NONE;
        req.pos          = idx_reg[IDX_W-1:0];
        req.entry.expire = time_reg;
        req.entry.tag    = tag_reg;
        req.entry.handle = handle_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next     = command;
                    handle_next  = handle;
                    time_next    = (command == CMD_TICK) ? now : expire;
                    tag_next     = client_tag;
                    idx_next     = '0;
                    pop_cnt_next = '0;
                    pend_next    = 1'b0;
                    // rejected commands answer right away
                    done_next    = 1'b0;
                    xv_next      = 1'b0;
                    xh_next      = '0;
                    xt_next      = '0;
                    last_next    = 1'b1;
                    case (command)
                        CMD_ADD:
                        begin
                            if (in_use_reg[handle] || full)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_IN_USE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_DELETE, CMD_ADJUST:
                        begin
                            if (!in_use_reg[handle])
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOT_USED;
                            end
                            else
                            begin
                                state_next = S_FIND;
                            end
                        end
                        CMD_TICK:
                        begin
                            state_next = S_POP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // step past every cell with expiry <= new expiry
                if ((idx_reg < count) && cmp.le)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                else
                begin
                    req.op                  = OP_INS;
                    in_use_next[handle_reg] = 1'b1;
                    done_next               = 1'b1;
                    status_next             = ST_OK;
                    xv_next                 = 1'b0;
                    xh_next                 = '0;
                    xt_next                 = '0;
                    last_next               = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            S_FIND:
            begin
                if (idx_reg >= count)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOT_USED;
                    xv_next     = 1'b0;
                    xh_next     = '0;
                    xt_next     = '0;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (cmp.eq)
                begin
                    req.op = OP_REM;
                    if (cmd_reg == CMD_DELETE)
                    begin
                        in_use_next[handle_reg] = 1'b0;
                        done_next               = 1'b1;
                        status_next             = ST_OK;
                        xv_next                 = 1'b0;
                        xh_next                 = '0;
                        xt_next                 = '0;
                        last_next               = 1'b1;
                        state_next              = S_IDLE;
                    end
                    else
                    begin
                        // adjust keeps the old tag and re-inserts
                        tag_next   = rd_cell.tag;
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            S_POP:
            begin
                // a popped timer is held in the pend registers so its last flag is known
                if (pop)
                begin
                    req.op                      = OP_REM;
                    req.pos                     = '0;
                    in_use_next[rd_cell.handle] = 1'b0;
                    pop_cnt_next                = pop_cnt_reg + POP_W'(1);
                    pend_next                   = 1'b1;
                    pend_handle_next            = rd_cell.handle;
                    pend_tag_next               = rd_cell.tag;
                    if (pend_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        xv_next     = 1'b1;
                        xh_next     = pend_handle_reg;
                        xt_next     = pend_tag_reg;
                        last_next   = 1'b0;
                    end
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    xv_next     = pend_reg;
                    xh_next     = pend_reg ? pend_handle_reg : '0;
                    xt_next     = pend_reg ? pend_tag_reg : '0;
                    last_next   = 1'b1;
                    pend_next   = 1'b0;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            in_use_reg  <= '0;
            pend_reg    <= 1'b0;
            pop_cnt_reg <= '0;
            idx_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            in_use_reg  <= in_use_next;
            pend_reg    <= pend_next;
            pop_cnt_reg <= pop_cnt_next;
            idx_reg     <= idx_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        handle_reg      <= handle_next;
        time_reg        <= time_next;
        tag_reg         <= tag_next;
        pend_handle_reg <= pend_handle_next;
        pend_tag_reg    <= pend_tag_next;
        status_reg      <= status_next;
        xv_reg          <= xv_next;
        xh_reg          <= xh_next;
        xt_reg          <= xt_next;
        last_reg        <= last_next;
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign expired_valid  = xv_reg;
    assign expired_handle = xh_reg;
    assign expired_tag    = xt_reg;
    assign last           = last_reg;

endmodule

@@ src/sorted_timer_queue_core.sv @@
// A rejected add/delete/adjust answers in the cycle after start. Add scans past the cells
// ahead of it, delete walks to the match, adjust walks to the match and then rescans.
// Tick with k due timers gives k words (one if none is due), on done in consecutive
// cycles. One command at a time; the store walk goes one cell per cycle through the
// shared compare unit. Results cannot be stalled.
// Reset (async, active low) empties the store and frees all handles at once.
// ----------------------------------------------------------------------------
// sorted_timer_queue_core: ascending sorted timer list
// Add, delete, adjust and tick commands over an expiry-ordered cell store.
// ----------------------------------------------------------------------------
module sorted_timer_queue_core import stq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             command,
    input  logic [HANDLE_BITS-1:0] handle,
    input  logic [TIME_BITS-1:0]   expire,
    input  logic [TAG_BITS-1:0]    client_tag,
    input  logic [TIME_BITS-1:0]   now,
    output logic                   done,
    output logic [1:0]             status,
    output logic                   expired_valid,
    output logic [HANDLE_BITS-1:0] expired_handle,
    output logic [TAG_BITS-1:0]    expired_tag,
    output logic                   last
);

    cell_t                  rd_cell;
    logic [CNT_W-1:0]       count;
    logic [IDX_W-1:0]       rd_idx;
    logic [TIME_BITS-1:0]   op_time;
    logic [HANDLE_BITS-1:0] op_handle;
    store_req_t             req;
    cmp_res_t               cmp;

    stq_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_idx  (rd_idx),
        .rd_cell (rd_cell),
        .count   (count)
    );

    stq_cmp u_cmp
    (
        .entry     (rd_cell),
        .op_time   (op_time),
        .op_handle (op_handle),
        .res       (cmp)
    );

    stq_seq u_seq
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .command        (command),
        .handle         (handle),
        .expire         (expire),
        .client_tag     (client_tag),
        .now            (now),
        .busy           (busy),
        .rd_cell        (rd_cell),
        .count          (count),
        .cmp            (cmp),
        .rd_idx         (rd_idx),
        .op_time        (op_time),
        .op_handle      (op_handle),
        .req            (req),
        .done           (done),
        .status         (status),
        .expired_valid  (expired_valid),
        .expired_handle (expired_handle),
        .expired_tag    (expired_tag),
        .last           (last)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(TIMERS))
        else $error("timer count exceeds store size");

    a_pop_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |=> (done && expired_valid))
        else $error("expired word burst broken");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_TICK) |=> busy)
        else $error("tick did not enter pop sequence");

    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        (req.op == OP_INS) |-> (count != CNT_W'(TIMERS)))
        else $error("insert into full store");
`endif

endmodule
